>>> design/prrts_pkg.sv
// shared codes for the priority round-robin task scheduler
`timescale 1ns / 1ps
package prrts_pkg;
    typedef logic [2:0] op_t;
    typedef logic [1:0] tstate_t;
    typedef logic [1:0] status_t;

    localparam op_t OP_CREATE    = 3'd0;
    localparam op_t OP_ACTIVATE  = 3'd1;
    localparam op_t OP_TERMINATE = 3'd2;
    localparam op_t OP_WAIT      = 3'd3;
    localparam op_t OP_TICK      = 3'd4;
    localparam op_t OP_START     = 3'd5;

    localparam tstate_t TS_SUSP  = 2'd0;
    localparam tstate_t TS_WAIT  = 2'd1;
    localparam tstate_t TS_READY = 2'd2;
    localparam tstate_t TS_RUN   = 2'd3;

    localparam status_t STS_OK      = 2'd0;
    localparam status_t STS_FULL    = 2'd1;
    localparam status_t STS_UNKNOWN = 2'd2;
    localparam status_t STS_OVF     = 2'd3;

    localparam logic [7:0] IDLE_PRIO = 8'd255;
endpackage

>>> design/priority_round_robin_task_scheduler_unit.sv
// top level of the priority round-robin task scheduler
`timescale 1ns / 1ps
// Takes one operation per input transaction and returns one result transaction. Internally a
// small sequencer walks the task table one entry per cycle. Create, bad-id and unused
// operations, a non-suspended activate and a tick while stopped go straight to the result.
// Activate/terminate/timed wait rebuild the ready queue (two passes over the table) and, when
// started, then make a decision. A tick walks the table once and makes a decision, after a
// rebuild when a task wakes. Start makes a decision, after a rebuild when it has to activate
// the idle task. The input is not ready while an item is in work or while a finished result
// waits for the output register; a result may wait in the output register while the next
// item is accepted.
module priority_round_robin_task_scheduler_unit #(
    parameter int MAX_TASKS   = 32,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[2:0], task_id[7:3], priority_req[15:8], wait_ticks[47:16]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], switch_request[2], current_task[7:3], next_task[12:8],
    // ready_count[17:13], zero fill above
    output logic [23:0] m_tdata
);
    localparam int TW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_TICK = 4'd2;
    localparam logic [3:0] S_REB  = 4'd3;
    localparam logic [3:0] S_REB1 = 4'd4;
    localparam logic [3:0] S_REB2 = 4'd5;
    localparam logic [3:0] S_DEC0 = 4'd6;
    localparam logic [3:0] S_DEC1 = 4'd7;
    localparam logic [3:0] S_DEC2 = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0]  state_reg;
    logic [7:0]  prio_reg [MAX_TASKS];
    prrts_pkg::tstate_t tst_reg [MAX_TASKS];
    logic [MAX_TASKS-1:0] blk_reg;
    logic [MAX_TASKS-1:0] inq_reg;
    logic [31:0] tk_reg [MAX_TASKS];
    logic [CW-1:0] total_reg;
    logic [4:0]  fifo_mem [QUEUE_DEPTH];
    logic [4:0]  fifo_rd_reg;
    logic [PW-1:0] head_reg, tail_reg;
    logic [FW-1:0] fill_reg;
    logic [TW-1:0] run_reg, chosen_reg, idx_reg, nx_reg;
    logic        on_reg, dec_reg, woke_reg, ovf_reg, sw_reg;
    logic [8:0]  best_reg;
    logic [7:0]  cur_prio_reg;
    prrts_pkg::status_t status_reg;
    prrts_pkg::op_t op_reg;
    logic [4:0]  id_reg;
    logic [7:0]  preq_reg;
    logic [31:0] wt_reg;
    logic        m_valid_reg;
    logic [23:0] m_data_reg;

    logic          push_req, push_do, idx_last, id_bad;
    logic [TW-1:0] push_val, id_idx, nx_w;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign idx_last = (32'(idx_reg) + 32'd1 >= 32'(total_reg));
    assign id_bad   = (32'(id_reg) >= 32'(total_reg));
    assign id_idx   = TW'(id_reg);
    assign nx_w     = TW'(fifo_rd_reg);

    always_comb begin
        push_req = 1'b0;
        push_val = run_reg;
        unique case (state_reg)
            S_REB2: begin
                push_req = (tst_reg[idx_reg] != prrts_pkg::TS_SUSP)
                    && ({1'b0, prio_reg[idx_reg]} == best_reg);
                push_val = idx_reg;
            end
            S_DEC0: push_req = (fill_reg == '0) && (tst_reg[run_reg] != prrts_pkg::TS_SUSP);
            S_DEC1: push_req = (nx_w != run_reg) && (tst_reg[run_reg] != prrts_pkg::TS_SUSP)
                && (cur_prio_reg == prio_reg[nx_w]) && !inq_reg[run_reg];
            default: push_req = 1'b0;
        endcase
        push_do = push_req && (32'(fill_reg) < QUEUE_DEPTH);
    end

    // ready queue storage with registered head read
    always_ff @(posedge aclk) begin
        if (push_do) begin
            fifo_mem[tail_reg] <= 5'(push_val);
        end
        fifo_rd_reg <= fifo_mem[head_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            for (int k = 0; k < MAX_TASKS; k++) begin
                prio_reg[k] <= (k == 0) ? prrts_pkg::IDLE_PRIO : 8'd0;
                tst_reg[k]  <= prrts_pkg::TS_SUSP;
                tk_reg[k]   <= 32'd0;
            end
            blk_reg     <= '0;
            inq_reg     <= '0;
            total_reg   <= CW'(1);
            head_reg    <= '0;
            tail_reg    <= '0;
            fill_reg    <= '0;
            run_reg     <= '0;
            chosen_reg  <= '0;
            on_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // in S_DONE the output register is reloaded below instead
            if (m_valid_reg && m_tready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            if (push_do) begin
                tail_reg <= (32'(tail_reg) == QUEUE_DEPTH - 1) ? '0 : tail_reg + PW'(1);
                fill_reg <= fill_reg + FW'(1);
                inq_reg[push_val] <= 1'b1;
            end else if (push_req) begin
                ovf_reg <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg     <= s_tdata[2:0];
                        id_reg     <= s_tdata[7:3];
                        preq_reg   <= s_tdata[15:8];
                        wt_reg     <= s_tdata[47:16];
                        status_reg <= prrts_pkg::STS_OK;
                        ovf_reg    <= 1'b0;
                        sw_reg     <= 1'b0;
                        woke_reg   <= 1'b0;
                        dec_reg    <= 1'b0;
                        state_reg  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    idx_reg   <= '0;
                    state_reg <= S_DONE;
                    priority if (op_reg == prrts_pkg::OP_CREATE) begin
                        if (32'(total_reg) >= MAX_TASKS) begin
                            status_reg <= prrts_pkg::STS_FULL;
                        end else begin
                            prio_reg[TW'(total_reg)] <= preq_reg;
                            tst_reg[TW'(total_reg)]  <= prrts_pkg::TS_SUSP;
                            blk_reg[TW'(total_reg)]  <= 1'b0;
                            tk_reg[TW'(total_reg)]   <= 32'd0;
                            total_reg <= total_reg + CW'(1);
                        end
                    end else if (op_reg == prrts_pkg::OP_ACTIVATE
                            || op_reg == prrts_pkg::OP_TERMINATE
                            || op_reg == prrts_pkg::OP_WAIT) begin
                        dec_reg <= on_reg;
                        if (id_bad) begin
                            status_reg <= prrts_pkg::STS_UNKNOWN;
                        end else if (op_reg == prrts_pkg::OP_ACTIVATE) begin
                            if (tst_reg[id_idx] == prrts_pkg::TS_SUSP) begin
                                tst_reg[id_idx] <= prrts_pkg::TS_WAIT;
                                blk_reg[id_idx] <= 1'b0;
                                state_reg <= S_REB;
                            end
                        end else begin
                            tst_reg[id_idx] <= prrts_pkg::TS_SUSP;
                            blk_reg[id_idx] <= (op_reg == prrts_pkg::OP_WAIT);
                            tk_reg[id_idx]  <= (op_reg == prrts_pkg::OP_WAIT) ? wt_reg : 32'd0;
                            state_reg <= S_REB;
                        end
                    end else if (op_reg == prrts_pkg::OP_TICK) begin
                        if (on_reg) begin
                            dec_reg   <= 1'b1;
                            state_reg <= S_TICK;
                        end
                    end else if (op_reg == prrts_pkg::OP_START) begin
                        on_reg     <= 1'b1;
                        run_reg    <= '0;
                        chosen_reg <= '0;
                        dec_reg    <= 1'b1;
                        if (tst_reg[0] == prrts_pkg::TS_SUSP) begin
                            tst_reg[0] <= prrts_pkg::TS_WAIT;
                            blk_reg[0] <= 1'b0;
                            state_reg  <= S_REB;
                        end else begin
                            state_reg <= S_DEC0;
                        end
                    end
                end
                S_TICK: begin
                    // counters stop at zero and wake the task on the next tick
                    if (tst_reg[idx_reg] == prrts_pkg::TS_SUSP && blk_reg[idx_reg]) begin
                        if (tk_reg[idx_reg] == 32'd0) begin
                            blk_reg[idx_reg] <= 1'b0;
                            tst_reg[idx_reg] <= prrts_pkg::TS_WAIT;
                            woke_reg <= 1'b1;
                        end else begin
                            tk_reg[idx_reg] <= tk_reg[idx_reg] - 32'd1;
                        end
                    end
                    idx_reg <= idx_last ? '0 : idx_reg + TW'(1);
                    if (idx_last) begin
                        if (woke_reg || (tst_reg[idx_reg] == prrts_pkg::TS_SUSP
                                && blk_reg[idx_reg] && tk_reg[idx_reg] == 32'd0)) begin
                            state_reg <= S_REB;
                        end else begin
                            state_reg <= S_DEC0;
                        end
                    end
                end
                S_REB: begin
                    head_reg  <= '0;
                    tail_reg  <= '0;
                    fill_reg  <= '0;
                    inq_reg   <= '0;
                    best_reg  <= 9'd256;
                    idx_reg   <= '0;
                    state_reg <= S_REB1;
                end
                S_REB1: begin
                    // first pass finds the best priority among live tasks
                    if (tst_reg[idx_reg] != prrts_pkg::TS_SUSP
                            && {1'b0, prio_reg[idx_reg]} < best_reg) begin
                        best_reg <= {1'b0, prio_reg[idx_reg]};
                    end
                    idx_reg <= idx_last ? '0 : idx_reg + TW'(1);
                    if (idx_last) begin
                        state_reg <= S_REB2;
                    end
                end
                S_REB2: begin
                    if (push_req) begin
                        tst_reg[idx_reg] <= prrts_pkg::TS_READY;
                    end
                    idx_reg <= idx_reg + TW'(1);
                    if (idx_last) begin
                        state_reg <= dec_reg ? S_DEC0 : S_DONE;
                    end
                end
                S_DEC0: begin
                    cur_prio_reg <= prio_reg[run_reg];
                    if (fill_reg == '0) begin
                        chosen_reg <= run_reg;
                        if (tst_reg[run_reg] != prrts_pkg::TS_SUSP) begin
                            tst_reg[run_reg] <= prrts_pkg::TS_RUN;
                        end
                        state_reg <= S_DONE;
                    end else begin
                        // pop: head entry lands in fifo_rd_reg next cycle
                        head_reg  <= (32'(head_reg) == QUEUE_DEPTH - 1) ? '0 : head_reg + PW'(1);
                        fill_reg  <= fill_reg - FW'(1);
                        state_reg <= S_DEC1;
                    end
                end
                S_DEC1: begin
                    inq_reg[nx_w] <= 1'b0;
                    chosen_reg <= nx_w;
                    nx_reg     <= nx_w;
                    if (nx_w == run_reg) begin
                        if (tst_reg[run_reg] != prrts_pkg::TS_SUSP) begin
                            tst_reg[run_reg] <= prrts_pkg::TS_RUN;
                        end
                        state_reg <= S_DONE;
                    end else begin
                        if (tst_reg[run_reg] == prrts_pkg::TS_RUN) begin
                            tst_reg[run_reg] <= prrts_pkg::TS_READY;
                        end
                        run_reg   <= nx_w;
                        sw_reg    <= 1'b1;
                        state_reg <= S_DEC2;
                    end
                end
                S_DEC2: begin
                    tst_reg[nx_reg] <= prrts_pkg::TS_RUN;
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {6'd0, 5'(fill_reg), 5'(chosen_reg), 5'(run_reg), sw_reg,
                            (status_reg == prrts_pkg::STS_OK && ovf_reg)
                                ? prrts_pkg::STS_OVF : status_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(fill_reg) <= QUEUE_DEPTH) else $error("ready queue fill beyond depth");
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg != '0 && 32'(total_reg) <= MAX_TASKS) else $error("task count out of range");
    a_run_known: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(run_reg) < 32'(total_reg)) else $error("running task not created");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("accepted while busy");
endmodule
